[design/sdepq_pkg.sv]
// sdepq_pkg: request codes, status codes and the per-cell control item
// shared by the queue top level and its cells
// no dependencies
package sdepq_pkg;

  localparam int VALUE_W = 32;

  // request codes
  localparam logic [1:0] REQ_INSERT     = 2'd0;
  localparam logic [1:0] REQ_REMOVE_MIN = 2'd1;
  localparam logic [1:0] REQ_REMOVE_MAX = 2'd2;
  localparam logic [1:0] REQ_REMOVE_VAL = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // cell operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_SHIFT  = 2'd2;
  localparam logic [1:0] CELL_SHIFT_GE = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic [1:0] op;
    value_t     val;
  } cell_ctl_t;

endpackage

[design/sdepq_cell.sv]
// sdepq_cell: one slot of the sorted chain, holds one value and compares
// it against the broadcast key; shifts from either neighbour on command
// depends on sdepq_pkg
module sdepq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                clk,
  input  sdepq_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]    cnt,
  input  sdepq_pkg::value_t   left_data,
  input  logic                left_gt,
  input  sdepq_pkg::value_t   right_data,
  output sdepq_pkg::value_t   data,
  output logic                gt,
  output logic                eq,
  output logic                last
);

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

  logic valid;

  assign valid = cnt > MY_IDX;
  assign gt    = valid && (ctl.val < data);
  assign eq    = valid && (ctl.val == data);
  assign last  = cnt == MY_NEXT;

  always_ff @(posedge clk) begin
    case (ctl.op)
      sdepq_pkg::CELL_INSERT: begin
        if (left_gt) begin
          data <= left_data;
        end else if (gt || cnt == MY_IDX) begin
          data <= ctl.val;
        end
      end
      sdepq_pkg::CELL_SHIFT: begin
        data <= right_data;
      end
      sdepq_pkg::CELL_SHIFT_GE: begin
        // sorted order: every slot at or past the first match holds >= key
        if (valid && !(data < ctl.val)) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[design/sorted_double_ended_priority_queue.sv]
// sorted_double_ended_priority_queue: top level, request sequencer and
// result registers around a chain of compare-and-shift cells
// depends on sdepq_pkg and sdepq_cell
//
// A request (req_type, value) is taken when start is high and busy is low.
// Each request passes through the accept edge, an execute state in which
// every cell compares the key and the cells shift, insert or hold together,
// and a result state in which the result is presented with done high. done
// lasts a single cycle and cannot be held off, so the receiver must take the
// item then. busy stays high from the accept edge until the result cycle
// ends, so a new request may be accepted in the cycle after done. The pace
// is set by the chain update followed by the min/max read-out of the updated
// chain, plus the idle state in which busy is low and the next item is taken.
// Values are kept in ascending signed order, equal inserts go after existing
// copies, and min_value/max_value read zero when the queue is empty.
module sorted_double_ended_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic signed [31:0] value,
  output logic        done,
  output logic [1:0]  status,
  output logic signed [31:0] removed_value,
  output logic [4:0]  count,
  output logic signed [31:0] min_value,
  output logic signed [31:0] max_value
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [1:0]              req;
  sdepq_pkg::value_t       key;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_next;
  logic [1:0]              status_r;
  logic [1:0]              status_next;
  sdepq_pkg::value_t       removed;
  sdepq_pkg::value_t       removed_next;
  sdepq_pkg::cell_ctl_t    ctl;
  logic [1:0]              cell_op;

  // chain wiring
  sdepq_pkg::value_t       cell_data [CAPACITY];
  sdepq_pkg::value_t       left_data [CAPACITY];
  sdepq_pkg::value_t       right_data [CAPACITY];
  logic [CAPACITY-1:0]     gt_vec;
  logic [CAPACITY-1:0]     eq_vec;
  logic [CAPACITY-1:0]     last_vec;
  logic [CAPACITY-1:0]     left_gt;

  logic                    found;
  logic                    full;
  logic                    empty;
  sdepq_pkg::value_t       last_data;

  assign busy  = state != S_IDLE;
  assign done  = state == S_DONE;
  assign full  = cnt == CNT_FULL;
  assign empty = cnt == '0;
  assign found = |eq_vec;

  // largest stored value: one-hot select of the slot just below the count
  always_comb begin
    last_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      last_data = last_data | (last_vec[i] ? cell_data[i] : '0);
    end
  end

  // request decode, applied to the chain only in the execute cycle
  always_comb begin
    cell_op      = sdepq_pkg::CELL_HOLD;
    status_next  = sdepq_pkg::ST_OK;
    removed_next = '0;
    cnt_next     = cnt;
    case (req)
      sdepq_pkg::REQ_INSERT: begin
        if (full) begin
          status_next = sdepq_pkg::ST_FULL;
        end else begin
          cell_op  = sdepq_pkg::CELL_INSERT;
          cnt_next = cnt + CNT_ONE;
        end
      end
      sdepq_pkg::REQ_REMOVE_MIN: begin
        if (empty) begin
          status_next = sdepq_pkg::ST_EMPTY;
        end else begin
          cell_op      = sdepq_pkg::CELL_SHIFT;
          removed_next = cell_data[0];
          cnt_next     = cnt - CNT_ONE;
        end
      end
      sdepq_pkg::REQ_REMOVE_MAX: begin
        if (empty) begin
          status_next = sdepq_pkg::ST_EMPTY;
        end else begin
          removed_next = last_data;
          cnt_next     = cnt - CNT_ONE;
        end
      end
      default: begin
        if (empty) begin
          status_next = sdepq_pkg::ST_EMPTY;
        end else if (!found) begin
          status_next = sdepq_pkg::ST_NOTFOUND;
        end else begin
          cell_op      = sdepq_pkg::CELL_SHIFT_GE;
          removed_next = key;
          cnt_next     = cnt - CNT_ONE;
        end
      end
    endcase
  end

  assign ctl.op  = (state == S_EXEC) ? cell_op : sdepq_pkg::CELL_HOLD;
  assign ctl.val = key;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        cnt <= cnt_next;
      end
    end
  end

  // request and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req <= req_type;
      key <= value;
    end
    if (state == S_EXEC) begin
      status_r <= status_next;
      removed  <= removed_next;
    end
  end

  // the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_data[i] = key;
      assign left_gt[i]   = 1'b0;
    end else begin : g_body
      assign left_data[i] = cell_data[i-1];
      assign left_gt[i]   = gt_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_data[i] = cell_data[i];
    end else begin : g_inner
      assign right_data[i] = cell_data[i+1];
    end

    sdepq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cnt        (cnt),
      .left_data  (left_data[i]),
      .left_gt    (left_gt[i]),
      .right_data (right_data[i]),
      .data       (cell_data[i]),
      .gt         (gt_vec[i]),
      .eq         (eq_vec[i]),
      .last       (last_vec[i])
    );
  end

  // result ports, meaningful while done is high
  assign status        = status_r;
  assign removed_value = removed;
  assign count         = 5'(cnt);
  assign min_value     = empty ? '0 : cell_data[0];
  assign max_value     = last_data;

  // at most one slot can be the top of the occupied range
  a_last_onehot : assert property (@(posedge clk) disable iff (rst)
    $onehot0(last_vec))
    else $error("more than one slot marked as largest");

  // occupancy never goes past the capacity
  a_cnt_range : assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_FULL)
    else $error("count beyond capacity");

  // a refused insert only happens on a full queue, and leaves it full
  a_full_refused : assert property (@(posedge clk) disable iff (rst)
    (done && status_r == sdepq_pkg::ST_FULL) |-> full)
    else $error("insert refused while space remained");

  // the count moves only in the execute cycle
  a_cnt_stable : assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC) |=> $stable(cnt))
    else $error("count changed outside execute cycle");

endmodule
